[hdl/euler_angles_to_basis_vectors_defines.svh]
// Assertion macros for the Euler angle to basis vector block.
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_DEFINES_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_DEFINES_SVH
// Check that an implication holds at every clock edge out of reset.
`define EAB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a signal is low while reset is applied.
`define EAB_ASSERT_RST(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) (!rst_n) |-> !(sig)) else $error(msg);
`endif

[hdl/eab_pkg.sv]
// Package with constants, tables and helpers of the Euler angle block.
package eab_pkg;
  localparam int CordicStages = 16;
  localparam int TableLen = 24;
  localparam int Stages = (CordicStages < TableLen) ? CordicStages : TableLen;
  localparam int AngW = 24;
  localparam int ZW = 34;
  localparam int XW = 34;
  localparam int OutW = 16;
  localparam int Latency = Stages + 7;

  localparam logic signed [XW-1:0] GainQ30 = 34'sd652032874;

  typedef logic signed [XW-1:0] cval_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    r = '0;
    unique case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round Q30 to Q1.15 and saturate.
  function automatic logic signed [OutW-1:0] to_q15(input logic signed [XW+1:0] v);
    logic signed [XW+1:0] r;
    r = (v + 36'sd16384) >>> 15;
    if (r > 36'sd32767) return 16'sd32767;
    else if (r < -36'sd32768) return -16'sd32768;
    else return r[OutW-1:0];
  endfunction
endpackage

[hdl/eab_sincos.sv]
// Pipelined angle reduction and CORDIC sine/cosine of one angle.
module eab_sincos
  import eab_pkg::*;
(
  input  logic                   clk_i,
  input  logic signed [AngW-1:0] ang_i,
  output cval_t                  sin_o,
  output cval_t                  cos_o
);
  // Stage A: modulo 92160 via reciprocal, quotient estimate.
  logic signed [AngW-1:0] ang_q;
  logic signed [AngW:0]   q_q;
  logic signed [50:0]     prod;
  assign prod = $signed({{27{ang_i[AngW-1]}}, ang_i}) * 51'sd11650;
  always_ff @(posedge clk_i) begin
    ang_q <= ang_i;
    q_q   <= 25'($signed(prod[50:30]));
  end

  // Stage B: remainder, corrected into [0, 92160).
  logic signed [AngW+1:0] rem0;
  logic signed [AngW+1:0] rem_q;
  assign rem0 = 26'(ang_q) - 26'(q_q * 25'sd92160);
  always_ff @(posedge clk_i) begin
    if (rem0 < 0) rem_q <= rem0 + 26'sd92160;
    else if (rem0 >= 26'sd92160) rem_q <= rem0 - 26'sd92160;
    else rem_q <= rem0;
  end

  // Stage C: fold into the right half plane.
  logic signed [18:0] t_q;
  logic               neg_c;
  always_ff @(posedge clk_i) begin
    if (rem_q >= 26'sd69120) begin
      t_q <= 19'(rem_q - 26'sd92160); neg_c <= 1'b0;
    end else if (rem_q > 26'sd23040) begin
      t_q <= 19'(26'sd46080 - rem_q); neg_c <= 1'b1;
    end else begin
      t_q <= 19'(rem_q); neg_c <= 1'b0;
    end
  end

  // Stage D: scale to Q30 radians.
  logic signed [52:0] zp;
  logic signed [ZW-1:0] z0_q;
  logic neg0_q;
  assign zp = $signed({{34{t_q[18]}}, t_q}) * $signed(53'sd4797524517);
  always_ff @(posedge clk_i) begin
    z0_q   <= ZW'(zp >>> 16);
    neg0_q <= neg_c;
  end

  // CORDIC rotation stages.
  cval_t x_q [Stages];
  cval_t y_q [Stages];
  logic signed [ZW-1:0] z_q [Stages];
  logic neg_q [Stages];
  cval_t xs [Stages];
  cval_t ys [Stages];
  logic signed [ZW-1:0] zs [Stages];
  logic ns [Stages];

  // Feed each stage from the scaled angle or from the stage before it.
  always_comb begin
    xs[0] = GainQ30;
    ys[0] = '0;
    zs[0] = z0_q;
    ns[0] = neg0_q;
    for (int i = 1; i < Stages; i++) begin
      xs[i] = x_q[i-1];
      ys[i] = y_q[i-1];
      zs[i] = z_q[i-1];
      ns[i] = neg_q[i-1];
    end
  end

  // Rotate each stage toward a zero residual angle.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Stages; i++) begin
      neg_q[i] <= ns[i];
      if (!zs[i][ZW-1]) begin
        x_q[i] <= xs[i] - (ys[i] >>> i);
        y_q[i] <= ys[i] + (xs[i] >>> i);
        z_q[i] <= zs[i] - atan_q30(i);
      end else begin
        x_q[i] <= xs[i] + (ys[i] >>> i);
        y_q[i] <= ys[i] - (xs[i] >>> i);
        z_q[i] <= zs[i] + atan_q30(i);
      end
    end
  end

  // Apply cosine sign.
  always_ff @(posedge clk_i) begin
    sin_o <= y_q[Stages-1];
    cos_o <= neg_q[Stages-1] ? -x_q[Stages-1] : x_q[Stages-1];
  end
endmodule

[hdl/euler_angles_to_basis_vectors.sv]
// Top level: Euler angles to forward, right and up basis vectors.
//
// Usage: drive pitch_deg_i, yaw_deg_i and roll_deg_i (degrees times 256)
// with start high for one cycle to issue a request. busy is never high,
// so a request is taken in every cycle in which start is high.
// Each request yields one result: nine Q1.15 components on the output ports
// with done_o high for exactly one cycle.
// The result passes four range reduction and scaling stages, one stage
// per CORDIC step, the cosine sign stage and two product stages.
// Throughput: one request per cycle; all stages are fully pipelined.
// Reset clears the valid bits; data registers are not reset.
// The receiver cannot stall; results are presented once and not held.
`include "euler_angles_to_basis_vectors_defines.svh"
module euler_angles_to_basis_vectors
  import eab_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [AngW-1:0] pitch_deg_i,
  input  logic signed [AngW-1:0] yaw_deg_i,
  input  logic signed [AngW-1:0] roll_deg_i,
  output logic                   done_o,
  output logic signed [OutW-1:0] fwd_x_o,
  output logic signed [OutW-1:0] fwd_y_o,
  output logic signed [OutW-1:0] fwd_z_o,
  output logic signed [OutW-1:0] rgt_x_o,
  output logic signed [OutW-1:0] rgt_y_o,
  output logic signed [OutW-1:0] rgt_z_o,
  output logic signed [OutW-1:0] upv_x_o,
  output logic signed [OutW-1:0] upv_y_o,
  output logic signed [OutW-1:0] upv_z_o
);
  assign busy = 1'b0;

  // Track request valid through the pipeline.
  logic [Latency-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Latency-2:0], start & ~busy};
  end
  assign done_o = vld_q[Latency-1];

  cval_t sp, cp, sy, cy, sr, cr;
  eab_sincos u_p (.clk_i, .ang_i(pitch_deg_i), .sin_o(sp), .cos_o(cp));
  eab_sincos u_y (.clk_i, .ang_i(yaw_deg_i),   .sin_o(sy), .cos_o(cy));
  eab_sincos u_r (.clk_i, .ang_i(roll_deg_i),  .sin_o(sr), .cos_o(cr));

  function automatic cval_t mq(cval_t a, cval_t b);
    logic signed [2*XW-1:0] p;
    p = a * b;
    return XW'(p >>> 30);
  endfunction

  // Product stage 1: pairwise products.
  cval_t srsp_q, crsp_q, cpcy_q, cpsy_q, crsy_q, crcy_q, srsy_q, srcy_q, srcp_q, crcp_q;
  cval_t sp1_q, cy1_q, sy1_q;
  always_ff @(posedge clk_i) begin
    srsp_q <= mq(sr, sp); crsp_q <= mq(cr, sp);
    cpcy_q <= mq(cp, cy); cpsy_q <= mq(cp, sy);
    crsy_q <= mq(cr, sy); crcy_q <= mq(cr, cy);
    srsy_q <= mq(sr, sy); srcy_q <= mq(sr, cy);
    srcp_q <= mq(sr, cp); crcp_q <= mq(cr, cp);
    sp1_q <= sp; cy1_q <= cy; sy1_q <= sy;
  end

  // Product stage 2: triple products, sums and rounding.
  always_ff @(posedge clk_i) begin
    fwd_x_o <= to_q15(36'(cpcy_q));
    fwd_y_o <= to_q15(36'(cpsy_q));
    fwd_z_o <= to_q15(-36'(sp1_q));
    rgt_x_o <= to_q15(-36'(mq(srsp_q, cy1_q)) + 36'(crsy_q));
    rgt_y_o <= to_q15(-36'(mq(srsp_q, sy1_q)) - 36'(crcy_q));
    rgt_z_o <= to_q15(-36'(srcp_q));
    upv_x_o <= to_q15(36'(mq(crsp_q, cy1_q)) + 36'(srsy_q));
    upv_y_o <= to_q15(36'(mq(crsp_q, sy1_q)) - 36'(srcy_q));
    upv_z_o <= to_q15(36'(crcp_q));
  end

  `EAB_ASSERT_RST(a_rst_done, clk_i, rst_ni, done_o, "done during reset")
  `EAB_ASSERT(a_lat, clk_i, rst_ni, done_o |-> $past(vld_q[Latency-2]), "done without request")
  `EAB_ASSERT(a_busy, clk_i, rst_ni, !busy, "busy raised")
endmodule
